// ----- rtl/core/orpsa_pkg.sv -----
`default_nettype none
package orpsa_pkg;

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 32;
    localparam int SUM_W    = 26;
    localparam int CNT_W    = 16;
    localparam int OFS_W    = 21;
    localparam int INTV_W   = 16;
    localparam int UV_W     = 24;
    localparam int PPM_W    = 14;
    localparam int BAND_W   = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET   = 1'b0,
        CFG_INTERVAL = 1'b1
    } t_cfg_idx;

    localparam int              MAX_SAMPLES_DEF = 65535;
    localparam logic [INTV_W-1:0] INTV_RESET    = 16'd1000;

    // Report queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_job;

    // Voltage scale: 5000000 / 1023 split into a whole part and a fraction.
    localparam int CODE_FULL  = 1023;
    localparam int VOLT_WHOLE = 4887;
    localparam int VOLT_FRAC  = 599;

    // Concentration constants.
    localparam int THRESH_UV = 380000;
    localparam int MICRO     = 1000000;
    localparam int SLOPE     = 10164;
    localparam int SQRT_BIAS = 4800;
    localparam int PPM_SHIFT = 400000000;
    localparam int PPM_MAX   = 5000;
    localparam int BAND_RED_MAX   = 2000;
    localparam int BAND_GREEN_MAX = 4000;
    localparam int PPM_MIN   = -351;

    // Division of the concentration by 10^6: a shift by 6, then a reciprocal
    // multiplication for the remaining division by 15625. The reciprocal is
    // ceil(2^43 / 15625), exact for every shifted value below 2^29.
    localparam int PPM_PRE_SHIFT   = 6;
    localparam int PPM_RECIP       = 562949954;
    localparam int PPM_RECIP_W     = 30;
    localparam int PPM_RECIP_SHIFT = 43;

    // Iterative divider and square root.
    localparam int DIVN_W      = 35;
    localparam int DIVD_W      = 20;
    localparam int SQRT_IN_W   = 44;
    localparam int SQRT_STEPS  = 22;
    localparam int ROOT_W      = 22;
    localparam int SREM_W      = 24;
    localparam int STEP_W      = 6;

    typedef enum logic [BAND_W-1:0] {
        BAND_OFF   = 2'd0,
        BAND_RED   = 2'd1,
        BAND_GREEN = 2'd2,
        BAND_BLUE  = 2'd3
    } t_band;

endpackage
`default_nettype wire

// ----- rtl/core/orpsa_front.sv -----
`default_nettype none
module orpsa_front #(
    parameter int MAX_SAMPLES = orpsa_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [orpsa_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [orpsa_pkg::TIME_W-1:0]   i_now_ms,
    input  wire logic [orpsa_pkg::INTV_W-1:0]   i_interval,
    input  wire logic                          i_full,
    output logic                               o_push,
    output orpsa_pkg::t_job                    o_job
);

    logic [orpsa_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [orpsa_pkg::CNT_W-1:0]  r_count, n_count;
    logic [orpsa_pkg::TIME_W-1:0] r_last;
    logic [orpsa_pkg::TIME_W-1:0] elapsed;
    logic                         accept;
    logic                         report;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // The sample of this transfer is counted before the interval test.
    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (r_count < orpsa_pkg::CNT_W'(MAX_SAMPLES)) begin
            n_sum   = r_sum + orpsa_pkg::SUM_W'(i_sample);
            n_count = r_count + orpsa_pkg::CNT_W'(1);
        end
    end

    assign elapsed = i_now_ms - r_last;
    assign report  = elapsed >= orpsa_pkg::TIME_W'(i_interval);

    assign o_push      = accept && report;
    assign o_job.sum   = n_sum;
    assign o_job.count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_last  <= '0;
        end else if (accept) begin
            if (report) begin
                r_sum   <= '0;
                r_count <= '0;
                r_last  <= i_now_ms;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/orpsa_queue.sv -----
`default_nettype none
module orpsa_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  orpsa_pkg::t_job      i_job,
    output logic                 o_full,
    output logic                 o_valid,
    output orpsa_pkg::t_job      o_job,
    input  wire logic            i_pop
);

    orpsa_pkg::t_job                 r_mem [orpsa_pkg::QDEPTH];
    logic [orpsa_pkg::QPTR_W-1:0]    r_wp;
    logic [orpsa_pkg::QPTR_W-1:0]    r_rp;
    logic [orpsa_pkg::QCNT_W-1:0]    r_fill;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = r_fill == orpsa_pkg::QCNT_W'(orpsa_pkg::QDEPTH);
    assign o_valid = r_fill != '0;
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                if (r_wp == orpsa_pkg::QPTR_W'(orpsa_pkg::QDEPTH - 1)) begin
                    r_wp <= '0;
                end else begin
                    r_wp <= r_wp + orpsa_pkg::QPTR_W'(1);
                end
            end
            if (do_pop) begin
                if (r_rp == orpsa_pkg::QPTR_W'(orpsa_pkg::QDEPTH - 1)) begin
                    r_rp <= '0;
                end else begin
                    r_rp <= r_rp + orpsa_pkg::QPTR_W'(1);
                end
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + orpsa_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - orpsa_pkg::QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/orpsa_back.sv -----
`default_nettype none
module orpsa_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_job_valid,
    input  orpsa_pkg::t_job                           i_job,
    output logic                                      o_pop,
    input  wire logic signed [orpsa_pkg::OFS_W-1:0]   i_offset,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [orpsa_pkg::SAMPLE_W-1:0]            o_average_code,
    output logic signed [orpsa_pkg::UV_W-1:0]         o_voltage_microvolts,
    output logic signed [orpsa_pkg::PPM_W-1:0]        o_ppm,
    output logic [orpsa_pkg::BAND_W-1:0]              o_led_band
);

    localparam int PW_W   = 23;
    localparam int PF_W   = 20;
    localparam int SB_W   = 23;
    localparam int PROD_W = 37;
    localparam int RQ_W   = orpsa_pkg::DIVN_W - orpsa_pkg::PPM_PRE_SHIFT;
    localparam int RP_W   = RQ_W + orpsa_pkg::PPM_RECIP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_VOLT_MUL,
        S_VOLT_SUM,
        S_SQ_MUL,
        S_SQRT,
        S_PPM_MUL,
        S_PPM_DIV,
        S_CLAMP,
        S_DONE
    } t_state;

    t_state                                   r_state;
    logic [orpsa_pkg::STEP_W-1:0]             r_step;

    // Restoring divider for the mean.
    logic [orpsa_pkg::DIVN_W-1:0]             r_num;
    logic [orpsa_pkg::DIVD_W-1:0]             r_rem;
    logic [orpsa_pkg::DIVD_W-1:0]             r_den;
    logic [orpsa_pkg::DIVD_W:0]               div_sh;
    logic                                     div_ge;
    logic [orpsa_pkg::DIVD_W:0]               div_diff;

    // Square root.
    logic [orpsa_pkg::SQRT_IN_W-1:0]          r_rad;
    logic [orpsa_pkg::ROOT_W-1:0]             r_root;
    logic [orpsa_pkg::SREM_W-1:0]             r_srem;
    logic [orpsa_pkg::SREM_W-1:0]             sq_sh;
    logic [orpsa_pkg::SREM_W-1:0]             sq_trial;
    logic                                     sq_ge;

    // Voltage path.
    logic [orpsa_pkg::SAMPLE_W-1:0]           r_avg;
    logic [PW_W-1:0]                          r_p_whole;
    logic [PF_W-1:0]                          r_p_frac;
    logic [orpsa_pkg::SAMPLE_W-1:0]           volt_q0;
    logic [orpsa_pkg::SAMPLE_W:0]             volt_r;
    logic [orpsa_pkg::SAMPLE_W-1:0]           volt_q;
    logic signed [orpsa_pkg::UV_W-1:0]        uv_next;
    logic signed [orpsa_pkg::UV_W-1:0]        r_uv;
    logic signed [orpsa_pkg::UV_W-1:0]        uv_diff;
    logic [PW_W-1:0]                          p_whole;
    logic [PF_W-1:0]                          p_frac;
    logic [orpsa_pkg::SQRT_IN_W-2:0]          rad_prod;

    // Concentration path.
    logic [SB_W-1:0]                          ppm_sb;
    logic [PROD_W-1:0]                        ppm_prod;
    logic signed [PROD_W-1:0]                 ppm_t;
    logic [PROD_W-1:0]                        ppm_mag;
    logic [RP_W-1:0]                          ppm_rprod;
    logic                                     r_tneg;
    logic signed [orpsa_pkg::PPM_W-1:0]       r_ppm;
    logic [orpsa_pkg::BAND_W-1:0]             r_band;
    logic [orpsa_pkg::BAND_W-1:0]             n_band;
    logic                                     r_out_valid;
    logic                                     out_load;

    function automatic logic [orpsa_pkg::DIVD_W-1:0] DIVD_W_MICRO();
        return orpsa_pkg::DIVD_W'(orpsa_pkg::MICRO);
    endfunction

    assign o_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_valid = r_out_valid;
    assign o_led_band = r_band;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // One quotient bit per step.
    assign div_sh   = {r_rem, r_num[orpsa_pkg::DIVN_W-1]};
    assign div_ge   = div_sh >= {1'b0, r_den};
    assign div_diff = div_sh - {1'b0, r_den};

    // Two radicand bits per step.
    assign sq_sh    = {r_srem[orpsa_pkg::SREM_W-3:0],
                       r_rad[orpsa_pkg::SQRT_IN_W-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign p_whole = r_num[orpsa_pkg::SAMPLE_W-1:0] * PW_W'(orpsa_pkg::VOLT_WHOLE);
    assign p_frac  = r_num[orpsa_pkg::SAMPLE_W-1:0] * PF_W'(orpsa_pkg::VOLT_FRAC);

    // floor(frac / 1023) with one correction, since the residue stays below 2 * 1023.
    assign volt_q0 = r_p_frac[PF_W-1 -: orpsa_pkg::SAMPLE_W];
    assign volt_r  = (orpsa_pkg::SAMPLE_W + 1)'(r_p_frac[orpsa_pkg::SAMPLE_W-1:0])
                   + (orpsa_pkg::SAMPLE_W + 1)'(volt_q0);
    assign volt_q  = (volt_r >= (orpsa_pkg::SAMPLE_W + 1)'(orpsa_pkg::CODE_FULL))
                   ? volt_q0 + orpsa_pkg::SAMPLE_W'(1) : volt_q0;
    assign uv_next = $signed(orpsa_pkg::UV_W'(r_p_whole))
                   + $signed(orpsa_pkg::UV_W'(volt_q))
                   + orpsa_pkg::UV_W'(i_offset);

    assign uv_diff  = r_uv - $signed(orpsa_pkg::UV_W'(orpsa_pkg::THRESH_UV));
    assign rad_prod = uv_diff[orpsa_pkg::UV_W-2:0] * DIVD_W_MICRO();

    assign ppm_sb   = SB_W'(r_root) + SB_W'(orpsa_pkg::SQRT_BIAS);
    assign ppm_prod = ppm_sb * PROD_W'(orpsa_pkg::SLOPE);
    assign ppm_t    = $signed(ppm_prod) - $signed(PROD_W'(orpsa_pkg::PPM_SHIFT));
    assign ppm_mag  = ppm_t[PROD_W-1] ? (PROD_W'(0) - ppm_t) : ppm_t;

    // Magnitude / 10^6: drop the factor 64 by a shift, then divide by 15625
    // with the reciprocal; the quotient sits above the reciprocal's shift.
    assign ppm_rprod = RP_W'(r_num[orpsa_pkg::DIVN_W-1:orpsa_pkg::PPM_PRE_SHIFT])
                     * RP_W'(orpsa_pkg::PPM_RECIP);

    // A report with zero or negative concentration keeps the previous band.
    always_comb begin
        n_band = r_band;
        if (r_ppm > 0 && r_ppm <= orpsa_pkg::PPM_W'(orpsa_pkg::BAND_RED_MAX)) begin
            n_band = orpsa_pkg::BAND_RED;
        end else if (r_ppm > orpsa_pkg::PPM_W'(orpsa_pkg::BAND_RED_MAX)
                     && r_ppm <= orpsa_pkg::PPM_W'(orpsa_pkg::BAND_GREEN_MAX)) begin
            n_band = orpsa_pkg::BAND_GREEN;
        end else if (r_ppm > orpsa_pkg::PPM_W'(orpsa_pkg::BAND_GREEN_MAX)) begin
            n_band = orpsa_pkg::BAND_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_band      <= orpsa_pkg::BAND_OFF;
            r_step      <= '0;
        end else begin
            if (r_out_valid && i_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_num   <= orpsa_pkg::DIVN_W'(i_job.sum);
                        r_den   <= orpsa_pkg::DIVD_W'(i_job.count);
                        r_rem   <= '0;
                        r_step  <= orpsa_pkg::STEP_W'(orpsa_pkg::DIVN_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_num  <= {r_num[orpsa_pkg::DIVN_W-2:0], div_ge};
                    r_rem  <= div_ge ? div_diff[orpsa_pkg::DIVD_W-1:0]
                                     : div_sh[orpsa_pkg::DIVD_W-1:0];
                    r_step <= r_step - orpsa_pkg::STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= S_VOLT_MUL;
                    end
                end
                S_VOLT_MUL: begin
                    r_avg     <= r_num[orpsa_pkg::SAMPLE_W-1:0];
                    r_p_whole <= p_whole;
                    r_p_frac  <= p_frac;
                    r_state   <= S_VOLT_SUM;
                end
                S_VOLT_SUM: begin
                    r_uv    <= uv_next;
                    r_state <= S_SQ_MUL;
                end
                S_SQ_MUL: begin
                    if (r_uv < $signed(orpsa_pkg::UV_W'(orpsa_pkg::THRESH_UV))) begin
                        r_ppm   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_rad   <= {1'b0, rad_prod};
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_step  <= orpsa_pkg::STEP_W'(orpsa_pkg::SQRT_STEPS - 1);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_rad  <= {r_rad[orpsa_pkg::SQRT_IN_W-3:0], 2'b00};
                    r_srem <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                    r_root <= {r_root[orpsa_pkg::ROOT_W-2:0], sq_ge};
                    r_step <= r_step - orpsa_pkg::STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= S_PPM_MUL;
                    end
                end
                S_PPM_MUL: begin
                    r_tneg  <= ppm_t[PROD_W-1];
                    r_num   <= ppm_mag[orpsa_pkg::DIVN_W-1:0];
                    r_state <= S_PPM_DIV;
                end
                S_PPM_DIV: begin
                    r_num   <= orpsa_pkg::DIVN_W'(ppm_rprod[RP_W-1:orpsa_pkg::PPM_RECIP_SHIFT]);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    // Truncation toward zero: negate the magnitude quotient.
                    if (r_tneg) begin
                        r_ppm <= orpsa_pkg::PPM_W'(0) - r_num[orpsa_pkg::PPM_W-1:0];
                    end else if (r_num > orpsa_pkg::DIVN_W'(orpsa_pkg::PPM_MAX)) begin
                        r_ppm <= orpsa_pkg::PPM_W'(orpsa_pkg::PPM_MAX);
                    end else begin
                        r_ppm <= r_num[orpsa_pkg::PPM_W-1:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        o_average_code       <= r_avg;
                        o_voltage_microvolts <= r_uv;
                        o_ppm                <= r_ppm;
                        r_band               <= n_band;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // The mean of samples never exceeds the largest code.
    a_avg_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VOLT_MUL) |-> (r_num[orpsa_pkg::DIVN_W-1:orpsa_pkg::SAMPLE_W] == '0))
        else $error("average quotient wider than a sample");

    a_ppm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ppm >= orpsa_pkg::PPM_W'(orpsa_pkg::PPM_MIN)
                     && o_ppm <= orpsa_pkg::PPM_W'(orpsa_pkg::PPM_MAX)))
        else $error("ppm out of range");

    a_below_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_voltage_microvolts < $signed(orpsa_pkg::UV_W'(orpsa_pkg::THRESH_UV)))
        |-> (o_ppm == '0))
        else $error("nonzero ppm below threshold voltage");

    a_band_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ppm > 0) |-> (o_led_band != orpsa_pkg::BAND_OFF))
        else $error("positive ppm with indicator off");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/orp_sensor_average_to_ppm_top.sv -----
// Averaging probe front end. Every input transfer carries one 10-bit converter
// sample and a millisecond timestamp; samples are summed and counted (the
// count saturates at MAX_SAMPLES, after which samples are ignored), and once
// report_interval_ms has elapsed since the last report (modulo 2^32) one result
// transfer follows with the mean code, the mean as microvolts plus the offset,
// a ppm estimate (zero below 380000 uV, at most 5000) and the indicator band.
// The input side takes one sample per clock; it stalls only while two reports
// are already queued for the back end. There a report passes through the
// one-bit-per-cycle divider for the mean and, unless the voltage is below
// threshold, the two-bit-per-cycle square root; the ppm scale is a reciprocal
// multiplication. Configuration writes take effect at once and should only be
// made while no report is pending.
`default_nettype none
module orp_sensor_average_to_ppm_top #(
    parameter int MAX_SAMPLES = orpsa_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Sample channel.
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [orpsa_pkg::SAMPLE_W-1:0]        i_sample,
    input  wire logic [orpsa_pkg::TIME_W-1:0]          i_now_ms,
    // Result channel.
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [orpsa_pkg::SAMPLE_W-1:0]             o_average_code,
    output logic signed [orpsa_pkg::UV_W-1:0]          o_voltage_microvolts,
    output logic signed [orpsa_pkg::PPM_W-1:0]         o_ppm,
    output logic [orpsa_pkg::BAND_W-1:0]               o_led_band,
    // Configuration write port.
    input  wire logic                                  i_cfg_we,
    input  wire logic [orpsa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [orpsa_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic signed [orpsa_pkg::OFS_W-1:0]  r_offset;
    logic [orpsa_pkg::INTV_W-1:0]        r_interval;

    logic                                q_full;
    logic                                q_push;
    logic                                q_valid;
    logic                                q_pop;
    orpsa_pkg::t_job                     front_job;
    orpsa_pkg::t_job                     back_job;

    // Configuration registers. Both register indexes are defined, so every
    // write lands in one of them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_interval <= orpsa_pkg::INTV_RESET;
        end else if (i_cfg_we) begin
            case (orpsa_pkg::t_cfg_idx'(i_cfg_index))
                orpsa_pkg::CFG_OFFSET: begin
                    r_offset <= $signed(i_cfg_data[orpsa_pkg::OFS_W-1:0]);
                end
                orpsa_pkg::CFG_INTERVAL: begin
                    r_interval <= i_cfg_data[orpsa_pkg::INTV_W-1:0];
                end
                default: begin
                    r_interval <= r_interval;
                end
            endcase
        end
    end

    // The front end accumulates samples up to MAX_SAMPLES and decides when a report
    // is due. A due report is handed off as a snapshot of the sum and count, so the
    // accumulation restarts in the same cycle.
    orpsa_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .i_now_ms   (i_now_ms),
        .i_interval (r_interval),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    // Pending reports wait here while the back end is busy.
    orpsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (back_job),
        .i_pop   (q_pop)
    );

    // The back end divides, scales, takes the square root and drives the
    // result register; it starts on the next report while a finished result
    // still waits for its transfer.
    orpsa_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_job_valid          (q_valid),
        .i_job                (back_job),
        .o_pop                (q_pop),
        .i_offset             (r_offset),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_average_code       (o_average_code),
        .o_voltage_microvolts (o_voltage_microvolts),
        .o_ppm                (o_ppm),
        .o_led_band           (o_led_band)
    );

endmodule
`default_nettype wire

// ----- tb/tb_orp_sensor_average_to_ppm_top.sv -----
`timescale 1ns / 1ps

module tb_orp_sensor_average_to_ppm_top;

    import orpsa_pkg::*;

    // A report spends at most this many cycles in the back end before it waits
    // for its result transfer; the queue in front of it holds two more, so a quiet
    // spell of this length is enough for anything still in flight to come out.
    localparam int unsigned BACKEND_CYCLES = 65;
    localparam int unsigned SETTLE_CYCLES  = 3 * BACKEND_CYCLES;
    // Long stall of the result side, used once to back the block up.
    localparam int unsigned HOLD_CYCLES    = 600;
    // Hard stop for the whole run, far above the slowest correct run.
    localparam longint      RUN_LIMIT_NS   = 64'd30_000_000;

    // The scoreboard keeps its own copy of the accumulator, the timer and
    // the configuration, and turns every accepted sample into the report that
    // it should cause, if any.
    class ppm_report_board;
        localparam int unsigned     SAMPLE_CAP     = 65535;
        localparam longint unsigned VOLT_SPAN_UV   = 64'd5000000;
        localparam longint unsigned CODE_SPAN      = 64'd1023;
        localparam longint          THRESHOLD_UV   = 64'sd380000;
        localparam longint          ROOT_OFFSET    = 64'sd4800;
        localparam longint          SLOPE_PER_ROOT = 64'sd10164;
        localparam longint          PPM_BASE       = 64'sd400000000;
        localparam longint          PPM_SCALE      = 64'sd1000000;
        localparam longint          PPM_CEILING    = 64'sd5000;
        localparam longint          RED_TOP        = 64'sd2000;
        localparam longint          GREEN_TOP      = 64'sd4000;

        typedef struct {
            logic [SAMPLE_W-1:0]      avg;
            logic signed [UV_W-1:0]   uv;
            logic signed [PPM_W-1:0]  ppm;
            logic [BAND_W-1:0]        band;
        } t_report;

        logic [SUM_W-1:0]         sum_q;
        logic [CNT_W-1:0]         count_q;
        logic [TIME_W-1:0]        last_q;
        t_band                    band_q;
        logic signed [OFS_W-1:0]  offset_q;
        logic [INTV_W-1:0]        interval_q;
        t_report                  pending_reports[$];
        int unsigned              errors;

        function new();
            sum_q      = '0;
            count_q    = '0;
            last_q     = '0;
            band_q     = BAND_OFF;
            offset_q   = '0;
            interval_q = 16'd1000;
            errors     = 0;
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] raw);
            case (idx)
                CFG_OFFSET:   offset_q = raw[OFS_W-1:0];
                CFG_INTERVAL: interval_q = raw[INTV_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] elapsed;
            longint unsigned   avg;
            longint unsigned   scaled;
            longint unsigned   root;
            longint            volt;
            longint            conc;
            t_report           rep;
            if (count_q < SAMPLE_CAP) begin
                sum_q   = sum_q + SUM_W'(smp);
                count_q = count_q + 1'b1;
            end
            elapsed = now - last_q;
            if (elapsed < TIME_W'(interval_q)) return;
            last_q = now;
            avg    = (count_q != 0) ? 64'(sum_q / count_q) : 64'd0;
            avg    = avg & 64'h3FF;
            scaled = avg * VOLT_SPAN_UV / CODE_SPAN;
            volt   = longint'(scaled) + longint'(offset_q);
            if (volt < THRESHOLD_UV) begin
                conc = 0;
            end else begin
                root = root_floor(64'(volt - THRESHOLD_UV) * 64'd1000000);
                conc = (SLOPE_PER_ROOT * (longint'(root) + ROOT_OFFSET) - PPM_BASE) / PPM_SCALE;
                if (conc > PPM_CEILING) conc = PPM_CEILING;
            end
            // Zero or negative estimates leave the indicator as it was.
            if (conc > 0 && conc <= RED_TOP) band_q = BAND_RED;
            else if (conc > RED_TOP && conc <= GREEN_TOP) band_q = BAND_GREEN;
            else if (conc > GREEN_TOP) band_q = BAND_BLUE;
            sum_q    = '0;
            count_q  = '0;
            rep.avg  = avg[SAMPLE_W-1:0];
            rep.uv   = volt[UV_W-1:0];
            rep.ppm  = conc[PPM_W-1:0];
            rep.band = band_q;
            pending_reports.push_back(rep);
        endfunction

        function void check_report(logic [SAMPLE_W-1:0] got_avg,
                                   logic signed [UV_W-1:0] got_uv,
                                   logic signed [PPM_W-1:0] got_ppm,
                                   logic [BAND_W-1:0] got_band);
            t_report want;
            if (pending_reports.size() == 0) begin
                $error("unexpected result transfer: average_code %0d voltage_microvolts %0d",
                       got_avg, got_uv);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            if (got_avg !== want.avg) begin
                $error("average_code: expected %0d, actual %0d", want.avg, got_avg);
                errors++;
            end
            if (got_uv !== want.uv) begin
                $error("voltage_microvolts: expected %0d, actual %0d", want.uv, got_uv);
                errors++;
            end
            if (got_ppm !== want.ppm) begin
                $error("ppm: expected %0d, actual %0d", want.ppm, got_ppm);
                errors++;
            end
            if (got_band !== want.band) begin
                $error("led_band: expected %0d, actual %0d", want.band, got_band);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_reports.size();
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [SAMPLE_W-1:0]         i_sample;
    logic [TIME_W-1:0]           i_now_ms;
    logic                        o_valid;
    logic                        i_ready;
    logic [SAMPLE_W-1:0]         o_average_code;
    logic signed [UV_W-1:0]      o_voltage_microvolts;
    logic signed [PPM_W-1:0]     o_ppm;
    logic [BAND_W-1:0]           o_led_band;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    // Set by the stimulus to ask the result side for one long hold-off; the
    // result side clears it when the hold-off is over.
    bit hold_req = 1'b0;

    ppm_report_board sb = new();

    orp_sensor_average_to_ppm_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_sample             (i_sample),
        .i_now_ms             (i_now_ms),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_average_code       (o_average_code),
        .o_voltage_microvolts (o_voltage_microvolts),
        .o_ppm                (o_ppm),
        .o_led_band           (o_led_band),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle spells: half of them none, most short, a few long.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // Offers one sample after an optional idle spell and returns once the
    // transfer has taken place. It is entered right after a rising edge, and
    // valid is only lowered when there is a gap, so back-to-back transfers
    // never see valid dropped and raised in the same step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp,
                               input logic [TIME_W-1:0] now,
                               input int unsigned gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        i_now_ms <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // One register write, then a cycle with the write enable low so that two
    // writes in a row never touch the enable twice in one step.
    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.apply_reg(idx, CFG_DATA_W'(value));
        @(posedge i_clk);
    endtask

    // Brings the block to rest: no sample offered, every expected report
    // received, and then a quiet spell for anything that produced no report.
    // The first edge lets the monitor note the last accepted sample before
    // the count of pending reports is looked at.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both channels are watched at the rising edge, where the values seen
    // are the ones that the edge acts on.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_report(o_average_code, o_voltage_microvolts, o_ppm, o_led_band);
            if (i_valid && o_ready)
                sb.note_sample(i_sample, i_now_ms);
        end
    end

    // Result side: ready runs of random length, mostly short stalls between
    // them, now and then a long run with no stall at all, and the one long
    // hold-off when the stimulus asks for it.
    initial begin
        int unsigned run;
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_ready <= 1'b1;
            run = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 12);
            repeat (run) @(posedge i_clk);
            stall = idle_len();
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        int              phase;
        int              n;
        int              items;
        int              intv;
        int              ofs;
        int              smp;
        int              level;
        int unsigned     roll;
        int unsigned     step_max;
        int unsigned     gap;
        bit              gaps_on;
        logic [TIME_W-1:0] clock_ms;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_now_ms    <= '0;
        i_ready     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_OFFSET;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With the reset interval of 1000 ms the first two
        // samples only accumulate and the third one reports the mean of all three.
        send_sample(10'd0, 32'd0, idle_len());
        send_sample(10'd1023, 32'd999, idle_len());
        send_sample(10'd1023, 32'd1000, idle_len());
        settle();

        // A one millisecond interval: each step walks through the bands. A
        // code of 77 falls below the threshold, so the band must stay red.
        write_reg(CFG_INTERVAL, 1);
        send_sample(10'd0, 32'd2000, idle_len());
        send_sample(10'd78, 32'd2001, idle_len());
        send_sample(10'd77, 32'd2002, idle_len());
        send_sample(10'd100, 32'd2003, idle_len());
        send_sample(10'd1023, 32'd2004, idle_len());
        send_sample(10'd78, 32'd2004, idle_len());
        send_sample(10'd78, 32'd2005, idle_len());
        settle();

        // An offset that puts the mean exactly on the threshold gives the
        // least estimate, which is negative and keeps the band.
        write_reg(CFG_OFFSET, -1231);
        send_sample(10'd78, 32'd2006, idle_len());
        settle();

        // Extremes of the offset field.
        write_reg(CFG_OFFSET, -1048576);
        send_sample(10'd0, 32'd2007, idle_len());
        send_sample(10'd1023, 32'd2008, idle_len());
        settle();
        write_reg(CFG_OFFSET, 1048575);
        send_sample(10'd1023, 32'd2009, idle_len());
        send_sample(10'd0, 32'd2010, idle_len());
        settle();

        // A zero interval reports on every step, even with the timer still.
        write_reg(CFG_OFFSET, 0);
        write_reg(CFG_INTERVAL, 0);
        send_sample(10'd512, 32'd2010, idle_len());
        send_sample(10'd513, 32'd2010, idle_len());
        settle();

        // Timer wrap: report just below the top of the 32-bit range, then
        // use the widest interval across the wrap, one short and one exact.
        write_reg(CFG_INTERVAL, 1);
        send_sample(10'd300, 32'hFFFF_FFF0, idle_len());
        settle();
        write_reg(CFG_INTERVAL, 65535);
        send_sample(10'd400, 32'h0000_FFE0, idle_len());
        send_sample(10'd401, 32'h0000_FFEF, idle_len());

        // Random part. Each phase sets both registers and then sends samples
        // clustered around a level near the threshold, where the estimate
        // crosses every band, mixed with samples over the full range and the
        // two extreme codes. The timer moves in steps sized to the interval
        // so that reports come every few samples, and now and then it jumps
        // to a random value, wraps included.
        for (phase = 0; phase < 8; phase++) begin
            items = 125;
            case (phase)
                0: begin
                    intv  = 0;
                    ofs   = 0;
                    items = 30;
                end
                1: begin
                    intv = 1;
                    ofs  = -1000000;
                end
                2: begin
                    intv = 65535;
                    ofs  = 1000000;
                end
                3: begin
                    intv = $urandom_range(1, 100);
                    ofs  = int'($urandom_range(0, 400000)) - 200000;
                end
                4: begin
                    intv = $urandom_range(0, 65535);
                    ofs  = $urandom_range(0, 21'h1F_FFFF);
                end
                5: begin
                    intv = 1000;
                    ofs  = 0;
                end
                6: begin
                    intv = $urandom_range(2, 20);
                    ofs  = -1048576;
                end
                default: begin
                    intv = $urandom_range(0, 65535);
                    ofs  = 1048575;
                end
            endcase
            settle();
            write_reg(CFG_OFFSET, ofs);
            write_reg(CFG_INTERVAL, intv);
            gaps_on  = (phase % 3 != 2);
            clock_ms = $urandom;
            step_max = intv / 4 + 1;
            // Every sample reports in the first phase, so a long hold-off on
            // the result side fills the report queue and stalls the input.
            if (phase == 0) hold_req = 1'b1;
            level = 100;
            for (n = 0; n < items; n++) begin
                if (n % 10 == 0) level = $urandom_range(60, 160);
                roll = $urandom_range(0, 99);
                if (roll < 70) smp = level + int'($urandom_range(0, 6)) - 3;
                else if (roll < 95) smp = $urandom_range(0, 1023);
                else smp = (roll < 98) ? 0 : 1023;
                if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
                else clock_ms = clock_ms + $urandom_range(0, step_max);
                gap = gaps_on ? idle_len() : 0;
                send_sample(SAMPLE_W'(smp), clock_ms, gap);
            end
        end

        settle();
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/orpsa_pkg.sv
rtl/core/orpsa_front.sv
rtl/core/orpsa_queue.sv
rtl/core/orpsa_back.sv
rtl/core/orp_sensor_average_to_ppm_top.sv
tb/tb_orp_sensor_average_to_ppm_top.sv
